// ===== sv/sparse_row_dot_product_defines.svh =====
// ---------------------------------------------------------------------------
// sparse row dot product assertion macros
// shared property shorthands for the port checker
// ---------------------------------------------------------------------------
`ifndef SPARSE_ROW_DOT_PRODUCT_DEFINES_SVH
`define SPARSE_ROW_DOT_PRODUCT_DEFINES_SVH

// same-cycle implication
`define SRDP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SRDP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/srdp_pkg.sv =====
// ---------------------------------------------------------------------------
// srdp_pkg
// shared types and constants of the sparse row dot product block
// ---------------------------------------------------------------------------
package srdp_pkg;

    localparam int COLUMN_W    = 10;
    localparam int VALUE_W     = 32;
    localparam int ROW_W       = 16;
    localparam int ACC_W       = 64;
    localparam int PROD_W      = 2 * VALUE_W - 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic
    {
        CMD_LOAD  = 1'b0,
        CMD_ENTRY = 1'b1
    } command_t;

    typedef enum logic
    {
        MODE_DOT    = 1'b0,
        MODE_SQUARE = 1'b1
    } mode_t;

    typedef struct packed
    {
        logic signed [PROD_W-1:0] prod;
        logic                     last;
    } queue_entry_t;

    typedef struct packed
    {
        logic             valid;
        logic [CNT_W-1:0] count;
    } queue_status_t;

endpackage

// ===== sv/srdp_ram.sv =====
// ---------------------------------------------------------------------------
// srdp_ram
// generic single-port ram with registered read data
// ---------------------------------------------------------------------------
module srdp_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/srdp_front.sv =====
// ---------------------------------------------------------------------------
// srdp_front
// accepts transactions, writes and reads the vector store, forms products
// ---------------------------------------------------------------------------
module srdp_front
#(
    parameter int VECTOR_DEPTH = 1024
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          command,
    input  logic [srdp_pkg::COLUMN_W-1:0] column,
    input  logic signed [srdp_pkg::VALUE_W-1:0] value,
    input  logic                          last,
    input  logic                          mode,
    input  srdp_pkg::queue_status_t       q_status,
    output logic                          push,
    output srdp_pkg::queue_entry_t        push_entry
);

    import srdp_pkg::*;

    localparam int AW = $clog2(VECTOR_DEPTH);

    logic                      accept;
    logic                      in_range;
    logic [AW-1:0]             addr;
    logic [CNT_W:0]            occupancy;
    logic [VALUE_W-1:0]        rd_data;
    logic signed [VALUE_W-1:0] other;
    logic signed [ACC_W-1:0]   prod_full;

    logic                      s1_valid_reg,    s1_valid_next;
    logic signed [VALUE_W-1:0] s1_value_reg;
    logic                      s1_last_reg;
    logic                      s1_in_range_reg;
    logic                      s2_valid_reg,    s2_valid_next;
    logic signed [PROD_W-1:0]  s2_prod_reg;
    logic                      s2_last_reg;

    assign occupancy = {1'b0, q_status.count} + (CNT_W+1)'(s1_valid_reg)
                     + (CNT_W+1)'(s2_valid_reg);
    assign in_ready  = occupancy < (CNT_W+1)'(QUEUE_DEPTH);
    assign accept    = in_valid && in_ready;
    assign in_range  = int'(column) < VECTOR_DEPTH;
    assign addr      = AW'(column);

    srdp_ram
    #(
        .WIDTH (VALUE_W),
        .DEPTH (VECTOR_DEPTH)
    )
    u_vector_ram
    (
        .clk   (clk),
        .we    (accept && command == CMD_LOAD && in_range),
        .re    (accept && command == CMD_ENTRY),
        .addr  (addr),
        .wdata (value),
        .rdata (rd_data)
    );

    // squared-norm mode ignores the column
    always_comb
    begin
        if (mode == MODE_SQUARE)
        begin
            other = s1_value_reg;
        end
        else if (s1_in_range_reg)
        begin
            other = $signed(rd_data);
        end
        else
        begin
            other = '0;
        end
        prod_full = s1_value_reg * other;
    end

    assign s1_valid_next = accept && command == CMD_ENTRY;
    assign s2_valid_next = s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_value_reg    <= value;
            s1_last_reg     <= last;
            s1_in_range_reg <= in_range;
        end
        // floor shift of the q32.32 product to q32.16
        s2_prod_reg <= prod_full[ACC_W-1:16];
        s2_last_reg <= s1_last_reg;
    end

    assign push            = s2_valid_reg;
    assign push_entry.prod = s2_prod_reg;
    assign push_entry.last = s2_last_reg;

endmodule

// ===== sv/srdp_queue.sv =====
// ---------------------------------------------------------------------------
// srdp_queue
// short product queue between the front and the accumulator
// ---------------------------------------------------------------------------
module srdp_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  srdp_pkg::queue_entry_t  push_entry,
    input  logic                    pop,
    output srdp_pkg::queue_entry_t  head,
    output srdp_pkg::queue_status_t status
);

    import srdp_pkg::*;

    queue_entry_t     slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    assign head         = slots[rd_ptr_reg];
    assign status.valid = count_reg != '0;
    assign status.count = count_reg;

endmodule

// ===== sv/srdp_back.sv =====
// ---------------------------------------------------------------------------
// srdp_back
// saturating accumulator, row end clamp and result register
// ---------------------------------------------------------------------------
module srdp_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  srdp_pkg::queue_entry_t       head,
    input  srdp_pkg::queue_status_t      q_status,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [srdp_pkg::VALUE_W-1:0] row_sum,
    output logic [srdp_pkg::ROW_W-1:0]   row_number,
    output logic                         saturated
);

    import srdp_pkg::*;

    logic signed [ACC_W-1:0]   addend;
    logic signed [ACC_W-1:0]   raw_sum;
    logic signed [ACC_W-1:0]   sum;
    logic                      add_ovf;
    logic                      clamped;
    logic signed [VALUE_W-1:0] clamp_val;
    logic                      slot_free;

    logic signed [ACC_W-1:0]   acc_reg,       acc_next;
    logic                      ovf_reg,       ovf_next;
    logic [ROW_W-1:0]          row_count_reg, row_count_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] row_sum_reg;
    logic [ROW_W-1:0]          row_number_reg;
    logic                      saturated_reg;

    assign slot_free = !out_valid_reg || out_ready;
    assign pop       = q_status.valid && (!head.last || slot_free);

    always_comb
    begin
        addend  = ACC_W'(head.prod);
        raw_sum = acc_reg + addend;
        add_ovf = (acc_reg[ACC_W-1] == addend[ACC_W-1])
               && (raw_sum[ACC_W-1] != acc_reg[ACC_W-1]);
        if (add_ovf)
        begin
            sum = acc_reg[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            sum = raw_sum;
        end
        clamped = !((&sum[ACC_W-1:VALUE_W-1]) || !(|sum[ACC_W-1:VALUE_W-1]));
        if (!clamped)
        begin
            clamp_val = sum[VALUE_W-1:0];
        end
        else if (sum[ACC_W-1])
        begin
            clamp_val = {1'b1, {(VALUE_W-1){1'b0}}};
        end
        else
        begin
            clamp_val = {1'b0, {(VALUE_W-1){1'b1}}};
        end

        acc_next       = acc_reg;
        ovf_next       = ovf_reg;
        row_count_next = row_count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (pop)
        begin
            if (head.last)
            begin
                acc_next       = '0;
                ovf_next       = 1'b0;
                row_count_next = row_count_reg + ROW_W'(1);
                out_valid_next = 1'b1;
            end
            else
            begin
                acc_next = sum;
                ovf_next = ovf_reg || add_ovf;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            row_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            row_count_reg <= row_count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.last)
        begin
            row_sum_reg    <= clamp_val;
            row_number_reg <= row_count_reg;
            saturated_reg  <= ovf_reg || add_ovf || clamped;
        end
    end

    assign out_valid  = out_valid_reg;
    assign row_sum    = row_sum_reg;
    assign row_number = row_number_reg;
    assign saturated  = saturated_reg;

endmodule

// ===== sv/sparse_row_dot_product.sv =====
// ---------------------------------------------------------------------------
// sparse_row_dot_product
// sparse row times dense vector, q16.16, saturating row sums
// ---------------------------------------------------------------------------
// input channel in_valid/in_ready carries command, column, value, last
// a load transaction writes value into the vector store at column
// an entry transaction multiplies value by the stored element, or by itself
// when mode is set, and adds the product to the row accumulator
// the entry marked last sends row_sum, row_number and saturated on the output
// channel out_valid/out_ready via the s1, s2, queue and result registers; it
// takes one transaction per cycle while in_ready is high: one vector ram read
// and one 32x32 multiply per entry, then one 64-bit add in the accumulator;
// a four-deep product queue sits between the multiplier and the accumulator;
// when the receiver stalls the queue fills and in_ready drops; the user must
// write mode through cfg_write/cfg_data only while the block is idle, not
// enforced by the block; reset clears accumulator, row counter, queue and
// mode; the vector store holds no reset value and needs no clearing pass
// ---------------------------------------------------------------------------
module sparse_row_dot_product
#(
    parameter int VECTOR_DEPTH = 1024
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic                                cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                command,
    input  logic [srdp_pkg::COLUMN_W-1:0]       column,
    input  logic signed [srdp_pkg::VALUE_W-1:0] value,
    input  logic                                last,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [srdp_pkg::VALUE_W-1:0] row_sum,
    output logic [srdp_pkg::ROW_W-1:0]          row_number,
    output logic                                saturated
);

    import srdp_pkg::*;

    logic          mode_reg, mode_next;
    logic          push;
    logic          pop;
    queue_entry_t  push_entry;
    queue_entry_t  head;
    queue_status_t q_status;

    assign mode_next = cfg_write ? cfg_data : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_DOT;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    srdp_front
    #(
        .VECTOR_DEPTH (VECTOR_DEPTH)
    )
    u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .column     (column),
        .value      (value),
        .last       (last),
        .mode       (mode_reg),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    srdp_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    srdp_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_status   (q_status),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .row_sum    (row_sum),
        .row_number (row_number),
        .saturated  (saturated)
    );

endmodule

// ===== sv/srdp_checker.sv =====
// ---------------------------------------------------------------------------
// srdp_checker
// port-level checks of the sparse row dot product block
// ---------------------------------------------------------------------------
`include "sparse_row_dot_product_defines.svh"

module srdp_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic                                cfg_data,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                command,
    input  logic [srdp_pkg::COLUMN_W-1:0]       column,
    input  logic signed [srdp_pkg::VALUE_W-1:0] value,
    input  logic                                last,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [srdp_pkg::VALUE_W-1:0] row_sum,
    input  logic [srdp_pkg::ROW_W-1:0]          row_number,
    input  logic                                saturated
);

    import srdp_pkg::*;

    logic             seen_reg,     seen_next;
    logic [ROW_W-1:0] prev_row_reg, prev_row_next;
    logic             mode_reg,     mode_next;
    logic             out_take;

    assign out_take      = out_valid && out_ready;
    assign seen_next     = seen_reg || out_take;
    assign prev_row_next = out_take ? row_number : prev_row_reg;
    assign mode_next     = cfg_write ? cfg_data : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= 1'b0;
            prev_row_reg <= '0;
            mode_reg     <= MODE_DOT;
        end
        else
        begin
            seen_reg     <= seen_next;
            prev_row_reg <= prev_row_next;
            mode_reg     <= mode_next;
        end
    end

    // a stalled result holds
    `SRDP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(row_sum) && $stable(row_number) && $stable(saturated),
        "stalled result changed")

    // rows are numbered in order
    `SRDP_ASSERT_NOW(a_row_order, clk, rst_n, out_take && seen_reg,
        row_number == prev_row_reg + ROW_W'(1), "row number skipped or repeated")

    // the first row after reset is row zero
    `SRDP_ASSERT_NOW(a_first_row, clk, rst_n, out_take && !seen_reg,
        row_number == '0, "first row number not zero")

    // a squared norm is never negative
    `SRDP_ASSERT_NOW(a_square_sign, clk, rst_n, out_valid && mode_reg == MODE_SQUARE,
        !row_sum[VALUE_W-1], "negative squared norm")

endmodule

bind sparse_row_dot_product srdp_checker u_srdp_checker (.*);
